// ----- src/mfsgd_pkg.sv -----
// Shared types, constants and helpers for the matrix factorization SGD trainer.
// Used by mfsgd_arith, mfsgd_ctrl, the top level and the testbench; no dependencies of its own.
package mfsgd_pkg;

   // sizes of the tables and the number format
   localparam int USER_COUNT    = 1024;
   localparam int ITEM_COUNT    = 1024;
   localparam int FACTOR_COUNT  = 2;
   localparam int FRACTION_BITS = 24;

   // address and counter widths
   localparam int UF_DEPTH = USER_COUNT * FACTOR_COUNT;
   localparam int IF_DEPTH = ITEM_COUNT * FACTOR_COUNT;
   localparam int UF_AW    = (UF_DEPTH > 1) ? $clog2(UF_DEPTH) : 1;
   localparam int IF_AW    = (IF_DEPTH > 1) ? $clog2(IF_DEPTH) : 1;
   localparam int UB_AW    = (USER_COUNT > 1) ? $clog2(USER_COUNT) : 1;
   localparam int IB_AW    = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;
   localparam int K_W      = (FACTOR_COUNT > 1) ? $clog2(FACTOR_COUNT) : 1;
   localparam int CLR_DEPTH = (USER_COUNT > ITEM_COUNT) ? USER_COUNT : ITEM_COUNT;
   localparam int CLR_W    = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

   // datapath widths
   localparam int PROD_W = 66;
   localparam int RND_W  = PROD_W - FRACTION_BITS;
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);

   // configuration reset values
   localparam logic [24:0] LR_RESET   = 25'd1678;
   localparam logic [24:0] REG_RESET  = 25'd1678;

   typedef enum logic [1:0] {
      FN_TRAIN     = 2'd0,
      FN_PREDICT   = 2'd1,
      FN_LOAD_USER = 2'd2,
      FN_LOAD_ITEM = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_LEARNING_RATE  = 2'd0,
      CSR_REGULARIZATION = 2'd1,
      CSR_GLOBAL_MEAN    = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DOT_RD,
      ST_DOT_MUL,
      ST_DOT_ACC,
      ST_PRED,
      ST_UPD_MB,
      ST_UPD_T,
      ST_UPD_MA,
      ST_UPD_W,
      ST_FAC_RD,
      ST_FAC_CAP,
      ST_FAC_MX,
      ST_FAC_X
   } state_type;

   // which table entry the running update writes
   typedef enum logic [1:0] {
      TGT_UBIAS,
      TGT_IBIAS,
      TGT_UFAC,
      TGT_IFAC
   } tgt_type;

   typedef struct packed {
      func_type           func;
      logic [9:0]         user_index;
      logic [9:0]         item_index;
      logic [3:0]         rating_value;
      logic [5:0]         factor_slot;
      logic signed [31:0] load_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] predicted_rating;
      logic signed [31:0] rating_error;
   } rsp_type;

   // sequencer to datapath
   typedef struct packed {
      state_type  st;
      tgt_type    tgt;
      logic       first;
      logic [3:0] rating;
   } arith_ctl_type;

   // sequencer to the four memories
   typedef struct packed {
      logic               uf_we;
      logic [UF_AW-1:0]   uf_waddr;
      logic [UF_AW-1:0]   uf_raddr;
      logic               if_we;
      logic [IF_AW-1:0]   if_waddr;
      logic [IF_AW-1:0]   if_raddr;
      logic signed [31:0] fac_wdata;
      logic               ub_we;
      logic [UB_AW-1:0]   ub_waddr;
      logic [UB_AW-1:0]   ub_raddr;
      logic               ib_we;
      logic [IB_AW-1:0]   ib_waddr;
      logic [IB_AW-1:0]   ib_raddr;
      logic signed [31:0] bias_wdata;
   } mem_ctl_type;

   // sequencer to response register
   typedef struct packed {
      logic rsp_load;
      logic zero_err;
   } rsp_ctl_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage

// ----- src/mfsgd_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mfsgd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/mfsgd_arith.sv -----
// Datapath: configuration registers, the shared multiplier, rounding, saturation
// and the working registers of the prediction and update steps. Uses mfsgd_pkg.
module mfsgd_arith import mfsgd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  arith_ctl_type      ctl,
   input  logic signed [31:0] uf_rd,
   input  logic signed [31:0] if_rd,
   input  logic signed [31:0] ub_rd,
   input  logic signed [31:0] ib_rd,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output logic signed [31:0] new_value,
   output logic signed [31:0] pred_value,
   output logic signed [31:0] err_value
);

   logic [24:0]        lr_ff, lr_in;
   logic [24:0]        rg_ff, rg_in;
   logic signed [31:0] gm_ff, gm_in;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [63:0]       acc_ff, acc_in;
   logic signed [31:0]       ub_ff, ub_in, ib_ff, ib_in;
   logic signed [31:0]       y_ff, y_in, x_ff, x_in, t_ff, t_in;
   logic signed [31:0]       p_ff, p_in, q_ff, q_in;
   logic signed [31:0]       err_ff, err_in;

   logic signed [32:0]       mul_a, mul_b;
   logic signed [PROD_W-1:0] rnd_sum;
   logic signed [RND_W-1:0]  rnd_w;
   logic signed [63:0]       rating_q;

   // configuration registers
   always_comb begin
      lr_in = lr_ff;
      rg_in = rg_ff;
      gm_in = gm_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LEARNING_RATE:  lr_in = csr_wdata[24:0];
            CSR_REGULARIZATION: rg_in = csr_wdata[24:0];
            CSR_GLOBAL_MEAN:    gm_in = $signed(csr_wdata);
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= LR_RESET;
         rg_ff <= REG_RESET;
         gm_ff <= '0;
      end else begin
         lr_ff <= lr_in;
         rg_ff <= rg_in;
         gm_ff <= gm_in;
      end
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctl.st)
         ST_DOT_MUL: begin
            mul_a = 33'(uf_rd);
            mul_b = 33'(if_rd);
         end
         ST_UPD_MB: begin
            mul_a = $signed(33'(rg_ff));
            mul_b = 33'(y_ff);
         end
         ST_UPD_MA: begin
            mul_a = $signed(33'(lr_ff));
            mul_b = 33'(t_ff);
         end
         ST_FAC_MX: begin
            mul_a = 33'(err_ff);
            mul_b = (ctl.tgt == TGT_UFAC) ? 33'(q_ff) : 33'(p_ff);
         end
         default: ;
      endcase
   end

   // round to nearest, ties up, back to the fraction width
   assign rnd_sum = prod_ff + RND_HALF;
   assign rnd_w   = rnd_sum[PROD_W-1:FRACTION_BITS];

   assign rating_q   = $signed(64'(ctl.rating) << FRACTION_BITS);
   assign pred_value = sat32(acc_ff);
   assign err_value  = sat32(rating_q - 64'(pred_value));
   assign new_value  = sat32(64'(y_ff) + 64'(rnd_w));

   // working registers
   always_comb begin
      prod_in = mul_a * mul_b;
      acc_in  = acc_ff;
      ub_in   = ub_ff;
      ib_in   = ib_ff;
      y_in    = y_ff;
      x_in    = x_ff;
      t_in    = t_ff;
      p_in    = p_ff;
      q_in    = q_ff;
      err_in  = err_ff;
      case (ctl.st)
         ST_DOT_MUL: begin
            ub_in = ub_rd;
            ib_in = ib_rd;
            if (ctl.first) begin
               acc_in = 64'(gm_ff) + 64'(ub_rd) + 64'(ib_rd);
            end
         end
         ST_DOT_ACC: acc_in = acc_ff + 64'(rnd_w);
         ST_PRED: begin
            err_in = err_value;
            y_in   = ub_ff;
            x_in   = err_value;
         end
         ST_UPD_T: t_in = sat32(64'(x_ff) - 64'(rnd_w));
         ST_UPD_W: begin
            if (ctl.tgt == TGT_UBIAS) begin
               y_in = ib_ff;
               x_in = err_ff;
            end else if (ctl.tgt == TGT_UFAC) begin
               p_in = new_value;
            end
         end
         ST_FAC_CAP: begin
            p_in = uf_rd;
            q_in = if_rd;
         end
         ST_FAC_X: begin
            x_in = sat32(64'(rnd_w));
            y_in = (ctl.tgt == TGT_UFAC) ? p_ff : q_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      ub_ff   <= ub_in;
      ib_ff   <= ib_in;
      y_ff    <= y_in;
      x_ff    <= x_in;
      t_ff    <= t_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      err_ff  <= err_in;
   end

endmodule

// ----- src/mfsgd_ctrl.sv -----
// Sequencer: bias clearing pass, item capture, the per-factor read-modify-write
// walk and the memory port control. Uses mfsgd_pkg.
module mfsgd_ctrl import mfsgd_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  req_type            req_data,
   input  logic               rsp_free,
   input  logic signed [31:0] new_value,
   output logic               req_ready,
   output arith_ctl_type      actl,
   output mem_ctl_type        mctl,
   output rsp_ctl_type        rctl
);

   state_type        st_ff, st_in;
   tgt_type          tgt_ff, tgt_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   req_type          item_ff, item_in;

   logic row_ok, slot_ok, accept, k_last, clr_last;

   assign row_ok  = (32'(req_data.user_index) < 32'(USER_COUNT)) &&
                    (32'(req_data.item_index) < 32'(ITEM_COUNT));
   assign slot_ok = 32'(req_data.factor_slot) < 32'(FACTOR_COUNT);
   assign accept  = req_valid && req_ready;
   assign k_last  = (k_ff == K_W'(FACTOR_COUNT - 1));
   assign clr_last = (clr_ff == CLR_W'(CLR_DEPTH - 1));

   // next state
   always_comb begin
      st_in   = st_ff;
      tgt_in  = tgt_ff;
      k_in    = k_ff;
      clr_in  = clr_ff;
      item_in = item_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            if (clr_last) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               item_in = req_data;
               k_in    = '0;
               if (row_ok && (req_data.func == FN_TRAIN || req_data.func == FN_PREDICT)) begin
                  st_in = ST_DOT_RD;
               end
            end
         end
         ST_DOT_RD:  st_in = ST_DOT_MUL;
         ST_DOT_MUL: st_in = ST_DOT_ACC;
         ST_DOT_ACC: begin
            if (k_last) begin
               st_in = ST_PRED;
            end else begin
               k_in  = k_ff + K_W'(1);
               st_in = ST_DOT_RD;
            end
         end
         ST_PRED: begin
            if (rsp_free) begin
               tgt_in = TGT_UBIAS;
               st_in  = (item_ff.func == FN_PREDICT) ? ST_IDLE : ST_UPD_MB;
            end
         end
         ST_UPD_MB: st_in = ST_UPD_T;
         ST_UPD_T:  st_in = ST_UPD_MA;
         ST_UPD_MA: st_in = ST_UPD_W;
         ST_UPD_W: begin
            unique case (tgt_ff)
               TGT_UBIAS: begin
                  tgt_in = TGT_IBIAS;
                  st_in  = ST_UPD_MB;
               end
               TGT_IBIAS: begin
                  tgt_in = TGT_UFAC;
                  k_in   = '0;
                  st_in  = ST_FAC_RD;
               end
               TGT_UFAC: begin
                  tgt_in = TGT_IFAC;
                  st_in  = ST_FAC_MX;
               end
               TGT_IFAC: begin
                  tgt_in = TGT_UFAC;
                  if (k_last) begin
                     st_in = ST_IDLE;
                  end else begin
                     k_in  = k_ff + K_W'(1);
                     st_in = ST_FAC_RD;
                  end
               end
               default: ;
            endcase
         end
         ST_FAC_RD:  st_in = ST_FAC_CAP;
         ST_FAC_CAP: st_in = ST_FAC_MX;
         ST_FAC_MX:  st_in = ST_FAC_X;
         ST_FAC_X:   st_in = ST_UPD_MB;
         default:    st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_CLEAR;
         tgt_ff <= TGT_UBIAS;
         k_ff   <= '0;
         clr_ff <= '0;
      end else begin
         st_ff  <= st_in;
         tgt_ff <= tgt_in;
         k_ff   <= k_in;
         clr_ff <= clr_in;
      end
      item_ff <= item_in;
   end

   // outputs
   always_comb begin
      req_ready = (st_ff == ST_IDLE);

      actl.st     = st_ff;
      actl.tgt    = tgt_ff;
      actl.first  = (k_ff == '0);
      actl.rating = item_ff.rating_value;

      rctl.rsp_load = (st_ff == ST_PRED) && rsp_free;
      rctl.zero_err = (item_ff.func == FN_PREDICT);

      mctl.uf_raddr = UF_AW'(32'(item_ff.user_index) * 32'(FACTOR_COUNT) + 32'(k_ff));
      mctl.if_raddr = IF_AW'(32'(item_ff.item_index) * 32'(FACTOR_COUNT) + 32'(k_ff));
      mctl.ub_raddr = UB_AW'(item_ff.user_index);
      mctl.ib_raddr = IB_AW'(item_ff.item_index);

      // factor writes: loads in idle, updates otherwise
      mctl.uf_we     = 1'b0;
      mctl.if_we     = 1'b0;
      mctl.uf_waddr  = mctl.uf_raddr;
      mctl.if_waddr  = mctl.if_raddr;
      mctl.fac_wdata = new_value;
      if (st_ff == ST_IDLE) begin
         mctl.uf_waddr  = UF_AW'(32'(req_data.user_index) * 32'(FACTOR_COUNT) +
                                 32'(req_data.factor_slot));
         mctl.if_waddr  = IF_AW'(32'(req_data.item_index) * 32'(FACTOR_COUNT) +
                                 32'(req_data.factor_slot));
         mctl.fac_wdata = req_data.load_value;
         mctl.uf_we     = accept && row_ok && slot_ok && (req_data.func == FN_LOAD_USER);
         mctl.if_we     = accept && row_ok && slot_ok && (req_data.func == FN_LOAD_ITEM);
      end else if (st_ff == ST_UPD_W) begin
         mctl.uf_we = (tgt_ff == TGT_UFAC);
         mctl.if_we = (tgt_ff == TGT_IFAC);
      end

      // bias writes: clearing pass, then updates
      mctl.ub_waddr   = mctl.ub_raddr;
      mctl.ib_waddr   = mctl.ib_raddr;
      mctl.bias_wdata = new_value;
      mctl.ub_we      = (st_ff == ST_UPD_W) && (tgt_ff == TGT_UBIAS);
      mctl.ib_we      = (st_ff == ST_UPD_W) && (tgt_ff == TGT_IBIAS);
      if (st_ff == ST_CLEAR) begin
         mctl.ub_waddr   = UB_AW'(clr_ff);
         mctl.ib_waddr   = IB_AW'(clr_ff);
         mctl.bias_wdata = '0;
         mctl.ub_we      = 32'(clr_ff) < 32'(USER_COUNT);
         mctl.ib_we      = 32'(clr_ff) < 32'(ITEM_COUNT);
      end
   end

endmodule

// ----- src/matrix_factor_sgd_trainer_unit.sv -----
// Top level of the biased matrix factorization SGD trainer.
// Depends on mfsgd_pkg, mfsgd_ram, mfsgd_arith and mfsgd_ctrl.
//
// Usage:
//  - req channel (valid/ready) takes one beat per operation: train, predict,
//    load user factor or load item factor. Loads are written from idle and
//    give no result. Out-of-range rows or slots are dropped without a result.
//  - rsp channel (valid/ready) gives one beat per train or predict: the
//    prediction before the update and the error (zero for predict).
//  - csr port: write enable, index and data; write only while idle.
//  - one item at a time. The result is loaded into the output register at
//    the prediction step once the register is free; a predict then goes
//    back to idle. Train runs on after the result through the bias and
//    factor updates before the next beat is accepted. The rate is set by
//    the single shared multiplier and the one read port of each table.
//  - the result sits in an output register: a running update goes on while
//    the receiver stalls, and the next train or predict waits at its
//    prediction step, with req_ready low, until the register is free.
//  - after reset a clearing pass zeroes the bias tables, one row per cycle;
//    req_ready stays low until it ends.
module matrix_factor_sgd_trainer_unit import mfsgd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   arith_ctl_type      actl;
   mem_ctl_type        mctl;
   rsp_ctl_type        rctl;
   logic signed [31:0] uf_rd, if_rd, ub_rd, ib_rd;
   logic signed [31:0] new_value, pred_value, err_value;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   mfsgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .new_value (new_value),
      .req_ready (req_ready),
      .actl      (actl),
      .mctl      (mctl),
      .rctl      (rctl)
   );

   mfsgd_arith u_arith (
      .clock      (clock),
      .reset      (reset),
      .ctl        (actl),
      .uf_rd      (uf_rd),
      .if_rd      (if_rd),
      .ub_rd      (ub_rd),
      .ib_rd      (ib_rd),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .new_value  (new_value),
      .pred_value (pred_value),
      .err_value  (err_value)
   );

   // factor and bias tables
   mfsgd_ram #(.WIDTH(32), .DEPTH(UF_DEPTH)) u_uf_ram (
      .clock (clock),
      .we    (mctl.uf_we),
      .waddr (mctl.uf_waddr),
      .wdata (mctl.fac_wdata),
      .raddr (mctl.uf_raddr),
      .rdata (uf_rd)
   );

   mfsgd_ram #(.WIDTH(32), .DEPTH(IF_DEPTH)) u_if_ram (
      .clock (clock),
      .we    (mctl.if_we),
      .waddr (mctl.if_waddr),
      .wdata (mctl.fac_wdata),
      .raddr (mctl.if_raddr),
      .rdata (if_rd)
   );

   mfsgd_ram #(.WIDTH(32), .DEPTH(USER_COUNT)) u_ub_ram (
      .clock (clock),
      .we    (mctl.ub_we),
      .waddr (mctl.ub_waddr),
      .wdata (mctl.bias_wdata),
      .raddr (mctl.ub_raddr),
      .rdata (ub_rd)
   );

   mfsgd_ram #(.WIDTH(32), .DEPTH(ITEM_COUNT)) u_ib_ram (
      .clock (clock),
      .we    (mctl.ib_we),
      .waddr (mctl.ib_waddr),
      .wdata (mctl.bias_wdata),
      .raddr (mctl.ib_raddr),
      .rdata (ib_rd)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rctl.rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_in.predicted_rating = pred_value;
         rsp_in.rating_error     = rctl.zero_err ? 32'sd0 : err_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // a new result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rctl.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten");

   // no factor write and no result while the bias tables are cleared
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (actl.st == ST_CLEAR) |-> (!mctl.uf_we && !mctl.if_we && !rsp_valid))
      else $error("activity during clearing pass");

   // the input side is closed whenever an update writes a table
   a_busy_write: assert property (@(posedge clock) disable iff (reset)
      (actl.st == ST_UPD_W) |-> !req_ready)
      else $error("input open during update write");
`endif

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the matrix factorization SGD trainer unit.
// Depends on mfsgd_pkg and matrix_factor_sgd_trainer_unit; a scoreboard class
// predicts each prediction and error beat from its own copy of the tables.
module tb_top import mfsgd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CSR_UNUSED = 2'd3;
   localparam int POOL = 12;
   localparam int RANDOM_ITEMS = 750;

   // prediction of the trainer tables and the expected result beats
   class rating_scoreboard;
      int      user_fac[UF_DEPTH];
      int      item_fac[IF_DEPTH];
      int      user_bias[USER_COUNT];
      int      item_bias[ITEM_COUNT];
      longint  alpha = 1678;
      longint  beta = 1678;
      longint  mean = 0;
      rsp_type pending_q[$];
      int      fails = 0;

      function longint clamp32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      // fixed-point product, round half up
      function longint fx_mul(longint a, longint b);
         longint p;
         p = a * b + (64'sd1 <<< (FRACTION_BITS - 1));
         return p >>> FRACTION_BITS;
      endfunction

      // y + alpha * (x - beta * y), each step clamped
      function int sgd_step(longint y, longint x);
         longint t;
         t = clamp32(x - fx_mul(beta, y));
         return int'(clamp32(y + fx_mul(alpha, t)));
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_LEARNING_RATE:  alpha = longint'(val[24:0]);
            CSR_REGULARIZATION: beta = longint'(val[24:0]);
            CSR_GLOBAL_MEAN:    mean = longint'($signed(val));
            default: ;
         endcase
      endfunction

      function void note_request(req_type r);
         int      ub, ib, np;
         longint  acc, pred, err, p, q;
         rsp_type e;
         ub = int'(r.user_index) * FACTOR_COUNT;
         ib = int'(r.item_index) * FACTOR_COUNT;
         if (r.func == FN_LOAD_USER || r.func == FN_LOAD_ITEM) begin
            if (r.factor_slot < FACTOR_COUNT) begin
               if (r.func == FN_LOAD_USER) user_fac[ub + r.factor_slot] = r.load_value;
               else item_fac[ib + r.factor_slot] = r.load_value;
            end
            return;
         end
         acc = mean + user_bias[r.user_index] + item_bias[r.item_index];
         for (int k = 0; k < FACTOR_COUNT; k++)
            acc += fx_mul(user_fac[ub + k], item_fac[ib + k]);
         pred = clamp32(acc);
         e.predicted_rating = pred[31:0];
         e.rating_error = '0;
         if (r.func == FN_TRAIN) begin
            err = clamp32((longint'(r.rating_value) <<< FRACTION_BITS) - pred);
            e.rating_error = err[31:0];
            user_bias[r.user_index] = sgd_step(user_bias[r.user_index], err);
            item_bias[r.item_index] = sgd_step(item_bias[r.item_index], err);
            for (int k = 0; k < FACTOR_COUNT; k++) begin
               p = user_fac[ub + k];
               q = item_fac[ib + k];
               np = sgd_step(p, clamp32(fx_mul(err, q)));
               user_fac[ub + k] = np;
               item_fac[ib + k] = sgd_step(q, clamp32(fx_mul(err, np)));
            end
         end
         pending_q = {pending_q, e};
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending_q.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h", $time, a);
            fails++;
            return;
         end
         e = pending_q.pop_front();
         if (a.predicted_rating !== e.predicted_rating) begin
            $display("%0t: predicted_rating expected %h actual %h", $time,
                     e.predicted_rating, a.predicted_rating);
            fails++;
         end
         if (a.rating_error !== e.rating_error) begin
            $display("%0t: rating_error expected %h actual %h", $time,
                     e.rating_error, a.rating_error);
            fails++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_LEARNING_RATE;
   logic [31:0] csr_wdata = '0;

   rating_scoreboard sb = new();
   bit          long_hold = 1'b0;
   logic [9:0]  user_pool[POOL];
   logic [9:0]  item_pool[POOL];

   matrix_factor_sgd_trainer_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int factor_value();
      if ($urandom_range(0, 19) == 0) return int'($urandom());
      return int'($urandom_range(0, 67108864)) - 33554432;
   endfunction

   // offer one beat and hold it until accepted
   task automatic send_beat(req_type r);
      int g;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_op(func_type f, logic [9:0] u, logic [9:0] it,
                          logic [5:0] slot, int val);
      req_type r;
      r.func = f;
      r.user_index = u;
      r.item_index = it;
      r.rating_value = 4'($urandom());
      r.factor_slot = slot;
      r.load_value = val;
      send_beat(r);
   endtask

   task automatic send_rated(func_type f, logic [3:0] rating);
      req_type r;
      r.func = f;
      r.user_index = user_pool[$urandom_range(0, POOL - 1)];
      r.item_index = item_pool[$urandom_range(0, POOL - 1)];
      r.rating_value = rating;
      r.factor_slot = 6'($urandom());
      r.load_value = int'($urandom());
      send_beat(r);
   endtask

   // wait for all results plus the tail of the last update
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // one register write, then the write enable drops again
   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_regs(logic [31:0] lr, logic [31:0] rg, logic [31:0] gm);
      write_csr(CSR_LEARNING_RATE, lr);
      write_csr(CSR_REGULARIZATION, rg);
      write_csr(CSR_GLOBAL_MEAN, gm);
   endtask

   task automatic random_items(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 50) send_rated(FN_TRAIN, 4'($urandom()));
         else if (r < 75) send_rated(FN_PREDICT, 4'($urandom()));
         else if (r < 90)
            send_op(r[0] ? FN_LOAD_USER : FN_LOAD_ITEM,
                    user_pool[$urandom_range(0, POOL - 1)],
                    item_pool[$urandom_range(0, POOL - 1)],
                    6'($urandom_range(0, FACTOR_COUNT - 1)), factor_value());
         else
            // loads anywhere, including ignored slots
            send_op(r[0] ? FN_LOAD_USER : FN_LOAD_ITEM, 10'($urandom()), 10'($urandom()),
                    6'($urandom()), int'($urandom()));
      end
   endtask

   // result sampling
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
   end

   // receiver: random stalls plus one long hold-off on request
   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         g = pick_gap();
         if (g > 0 && $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   // main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // let the bias clearing pass finish before touching registers
      do @(posedge clock); while (!req_ready);
      write_csr(CSR_UNUSED, 32'hffffffff);

      // pool rows, extremes of the index range included
      for (int i = 0; i < POOL; i++) begin
         user_pool[i] = (i == 0) ? 10'd0 : (i == 1) ? 10'd1023 : 10'($urandom());
         item_pool[i] = (i == 0) ? 10'd1023 : (i == 1) ? 10'd0 : 10'($urandom());
      end
      // directed: load every pool row, extremes among the values
      for (int i = 0; i < POOL; i++) begin
         for (int k = 0; k < FACTOR_COUNT; k++) begin
            send_op(FN_LOAD_USER, user_pool[i], 10'd0, 6'(k),
                    (i == 0) ? 32'sh7fffffff : (i == 1) ? 32'sh80000000 : factor_value());
            send_op(FN_LOAD_ITEM, 10'd0, item_pool[i], 6'(k),
                    (i == 0) ? 32'sh80000000 : (i == 1) ? 0 : factor_value());
         end
      end
      // out-of-range slot loads are dropped
      send_op(FN_LOAD_USER, user_pool[2], 10'd0, 6'd63, 32'sh7fffffff);
      send_op(FN_LOAD_ITEM, 10'd0, item_pool[2], 6'd2, 32'sh80000000);
      send_rated(FN_TRAIN, 4'd0);
      send_rated(FN_TRAIN, 4'd15);
      send_rated(FN_PREDICT, 4'd15);
      drain();

      // random phases across register settings
      set_regs(32'd16777216, 32'd0, 32'h7fffffff);
      long_hold = 1'b1;
      random_items(RANDOM_ITEMS / 5);
      drain();
      set_regs(32'd0, 32'd16777216, 32'h80000000);
      random_items(RANDOM_ITEMS / 5);
      drain();
      set_regs(32'hfe000000 | $urandom_range(0, 65536), $urandom(),
               int'($urandom_range(0, 83886080)) - 16777216);
      random_items(RANDOM_ITEMS / 5);
      drain();
      set_regs(32'd1678, 32'd1678, 32'd50331648);
      random_items(RANDOM_ITEMS - 3 * (RANDOM_ITEMS / 5));
      drain();

      if (sb.fails == 0 && sb.pending_q.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
